### hdl/bsce_pkg.sv
// ----------------------------------------------------------------------------
// bsce_pkg - shared definitions for the B-spline curve point evaluator
// Field widths, codes, the controller/datapath command and status structs,
// and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package bsce_pkg;

	localparam int KNOT_W     = 17;
	localparam int COORD_W    = 32;
	localparam int BASIS_W    = 32;
	localparam int MODE_W     = 2;
	localparam int INDEX_W    = 6;
	localparam int SPAN_W     = 6;
	localparam int STATUS_W   = 2;
	localparam int DEG_W      = 2;
	localparam int LAST_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int CNT_W      = 3;
	localparam int CRD_W      = 2;
	localparam int S_TDATA_W  = 120;
	localparam int M_TDATA_W  = 104;

	localparam int DEF_MAX_DEGREE = 3;
	localparam int DEF_MAX_CTRL   = 32;
	localparam int DEF_FRAC_BITS  = 16;

	localparam logic [MODE_W-1:0] MODE_KNOT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CTRL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EVAL = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST   = 1'b1;

	localparam logic [DEG_W-1:0]  RST_DEGREE = 2'd3;
	localparam logic [LAST_W-1:0] RST_LAST   = 5'd3;

	localparam logic [CRD_W-1:0] CRD_LAST = 2'd2;

	typedef enum logic [4:0] {
		OP_NOP, OP_WR_KNOT, OP_WR_CTRL, OP_LOAD,
		OP_RD_END, OP_CK_END, OP_RD_MID, OP_CK_MID,
		OP_RD_LEFT, OP_SET_LEFT, OP_RD_RIGHT, OP_SET_RIGHT,
		OP_DEN, OP_MUL_A, OP_MUL_B, OP_DIV_START, OP_SAVE_A, OP_UPD, OP_ENDJ,
		OP_RD_CTRL, OP_MUL_P, OP_ACC, OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [CNT_W-1:0] j;
		logic [CNT_W-1:0] r;
		logic [CNT_W-1:0] t;
		logic [CRD_W-1:0] c;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] p;
		logic             end_hit;
		logic             srch_done;
		logic             den_zero;
		logic             div_done;
		logic             out_free;
	} sts_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] val;
	} sat_t;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t s;
		if (v > SAT_MAX) begin
			s.hit = 1'b1;
			s.val = 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			s.hit = 1'b1;
			s.val = 32'sh80000000;
		end else begin
			s.hit = 1'b0;
			s.val = 32'(v);
		end
		return s;
	endfunction

endpackage

### hdl/bspline_curve_point_eval.sv
// ----------------------------------------------------------------------------
// bspline_curve_point_eval - point on a degree-p B-spline curve
// Top level: stream ports, field packing and the controller/datapath pair.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries a mode in s_tuser. A knot write
// or a control point write is taken in the idle state and produces nothing. An
// evaluation request finds the knot span by binary search, builds the p+1
// basis values with the triangular Cox-de Boor recurrence, and returns one
// result on the master stream: the saturated point, the span and a status.
// Mode 3 and writes to an index past the store are dropped silently.
// The shared serial divider yields two quotient bits a cycle and runs twice
// for every recurrence step; a step that meets a zero knot interval skips
// the divider. Only one evaluation is in flight at a time.
// s_tready is high while the sequencer is idle; a finished result sits in
// the output register, so the next request is taken even if the receiver
// stalls, and a second evaluation waits at its end for the register to free.
// Reset gives degree 3 and last control index 3, clears the basis scratch
// and drops m_tvalid. Knot and control point memories are not cleared and
// must be written before use. Write configuration while idle (not enforced).
// ----------------------------------------------------------------------------
module bspline_curve_point_eval import bsce_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int MAX_CTRL   = DEF_MAX_CTRL,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// index[5:0], param_value[22:6], coord_x[54:23], coord_y[86:55],
	// coord_z[118:87], zero pad[119]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// point_x[31:0], point_y[63:32], point_z[95:64], span_found[101:96],
	// zero pad[103:102]
	output logic [M_TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [STATUS_W-1:0]   m_tuser,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t st;
	logic [COORD_W-1:0] point_x, point_y, point_z;
	logic [SPAN_W-1:0]  span_found;

	// The sequencer issues one datapath command a cycle and follows status.
	bsce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_mode  (s_tuser),
		.req_ready (s_tready),
		.st        (st),
		.cmd       (cmd)
	);

	// Field extraction follows the packing listed beside s_tdata.
	bsce_dp #(
		.MAX_DEGREE (MAX_DEGREE),
		.MAX_CTRL   (MAX_CTRL),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_index   (s_tdata[5:0]),
		.in_param   (s_tdata[22:6]),
		.in_x       (s_tdata[54:23]),
		.in_y       (s_tdata[86:55]),
		.in_z       (s_tdata[118:87]),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.span_found (span_found),
		.status     (m_tuser)
	);

	assign m_tdata = {2'b00, span_found, point_z, point_y, point_x};

endmodule

### hdl/bsce_ctrl.sv
// ----------------------------------------------------------------------------
// bsce_ctrl - sequencer for the B-spline curve point evaluator
// One-hot state machine that walks the span search, the knot difference
// fetch, the triangular recurrence and the weighted sum.
// ----------------------------------------------------------------------------
module bsce_ctrl import bsce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [MODE_W-1:0] req_mode,
	output logic              req_ready,
	input  sts_t              st,
	output cmd_t              cmd
);

	typedef enum logic [21:0] {
		S_IDLE    = 22'h000001,
		S_END_RD  = 22'h000002,
		S_END_CK  = 22'h000004,
		S_SRCH_RD = 22'h000008,
		S_SRCH_CK = 22'h000010,
		S_LR_RDL  = 22'h000020,
		S_LR_CKL  = 22'h000040,
		S_LR_RDR  = 22'h000080,
		S_LR_CKR  = 22'h000100,
		S_REC_DEN = 22'h000200,
		S_REC_MA  = 22'h000400,
		S_REC_DSA = 22'h000800,
		S_REC_DWA = 22'h001000,
		S_REC_MB  = 22'h002000,
		S_REC_DSB = 22'h004000,
		S_REC_DWB = 22'h008000,
		S_REC_UPD = 22'h010000,
		S_REC_ENDJ = 22'h020000,
		S_SUM_RD  = 22'h040000,
		S_SUM_MUL = 22'h080000,
		S_SUM_ACC = 22'h100000,
		S_FIN     = 22'h200000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] j_q, j_d, r_q, r_d, t_q, t_d;
	logic [CRD_W-1:0] c_q, c_d;
	dp_op_t           op;

	assign req_ready = (state_q == S_IDLE);
	assign cmd.op = op;
	assign cmd.j  = j_q;
	assign cmd.r  = r_q;
	assign cmd.t  = t_q;
	assign cmd.c  = c_q;

	always_comb begin
		state_d = state_q;
		j_d = j_q;
		r_d = r_q;
		t_d = t_q;
		c_d = c_q;
		op  = OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_mode)
						MODE_KNOT: op = OP_WR_KNOT;
						MODE_CTRL: op = OP_WR_CTRL;
						MODE_EVAL: begin
							op = OP_LOAD;
							state_d = S_END_RD;
						end
						default: op = OP_NOP;
					endcase
				end
			end
			S_END_RD: begin
				op = OP_RD_END;
				state_d = S_END_CK;
			end
			S_END_CK: begin
				op = OP_CK_END;
				if (st.end_hit) begin
					j_d = CNT_W'(1);
					state_d = S_LR_RDL;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (st.srch_done) begin
					j_d = CNT_W'(1);
					state_d = S_LR_RDL;
				end else begin
					op = OP_RD_MID;
					state_d = S_SRCH_CK;
				end
			end
			S_SRCH_CK: begin
				op = OP_CK_MID;
				state_d = S_SRCH_RD;
			end
			S_LR_RDL: begin
				op = OP_RD_LEFT;
				state_d = S_LR_CKL;
			end
			S_LR_CKL: begin
				op = OP_SET_LEFT;
				state_d = S_LR_RDR;
			end
			S_LR_RDR: begin
				op = OP_RD_RIGHT;
				state_d = S_LR_CKR;
			end
			S_LR_CKR: begin
				op = OP_SET_RIGHT;
				if (j_q == st.p) begin
					j_d = CNT_W'(1);
					r_d = '0;
					state_d = S_REC_DEN;
				end else begin
					j_d = j_q + CNT_W'(1);
					state_d = S_LR_RDL;
				end
			end
			S_REC_DEN: begin
				op = OP_DEN;
				if (st.den_zero) begin
					if (r_q + CNT_W'(1) == j_q) begin
						state_d = S_REC_ENDJ;
					end else begin
						r_d = r_q + CNT_W'(1);
					end
				end else begin
					state_d = S_REC_MA;
				end
			end
			S_REC_MA: begin
				op = OP_MUL_A;
				state_d = S_REC_DSA;
			end
			S_REC_DSA: begin
				op = OP_DIV_START;
				state_d = S_REC_DWA;
			end
			S_REC_DWA: begin
				if (st.div_done) begin
					op = OP_SAVE_A;
					state_d = S_REC_MB;
				end
			end
			S_REC_MB: begin
				op = OP_MUL_B;
				state_d = S_REC_DSB;
			end
			S_REC_DSB: begin
				op = OP_DIV_START;
				state_d = S_REC_DWB;
			end
			S_REC_DWB: begin
				if (st.div_done) state_d = S_REC_UPD;
			end
			S_REC_UPD: begin
				op = OP_UPD;
				if (r_q + CNT_W'(1) == j_q) begin
					state_d = S_REC_ENDJ;
				end else begin
					r_d = r_q + CNT_W'(1);
					state_d = S_REC_DEN;
				end
			end
			S_REC_ENDJ: begin
				op = OP_ENDJ;
				if (j_q == st.p) begin
					t_d = '0;
					c_d = '0;
					state_d = S_SUM_RD;
				end else begin
					j_d = j_q + CNT_W'(1);
					r_d = '0;
					state_d = S_REC_DEN;
				end
			end
			S_SUM_RD: begin
				op = OP_RD_CTRL;
				state_d = S_SUM_MUL;
			end
			S_SUM_MUL: begin
				op = OP_MUL_P;
				state_d = S_SUM_ACC;
			end
			S_SUM_ACC: begin
				op = OP_ACC;
				if (c_q == CRD_LAST) begin
					c_d = '0;
					if (t_q == st.p) begin
						state_d = S_FIN;
					end else begin
						t_d = t_q + CNT_W'(1);
						state_d = S_SUM_RD;
					end
				end else begin
					c_d = c_q + CRD_W'(1);
					state_d = S_SUM_MUL;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					op = OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			r_q <= '0;
			t_q <= '0;
			c_q <= '0;
		end else begin
			state_q <= state_d;
			j_q <= j_d;
			r_q <= r_d;
			t_q <= t_d;
			c_q <= c_d;
		end
	end

	// Every recurrence step lies inside the triangle: 0 <= r < j <= p.
	a_rec_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REC_DEN) |-> (r_q < j_q && j_q <= st.p && j_q != '0))
		else $error("recurrence counters left the triangle");

endmodule

### hdl/bsce_dp.sv
// ----------------------------------------------------------------------------
// bsce_dp - datapath of the B-spline curve point evaluator
// Knot and control point memories, span search registers, basis scratch,
// one shared 32x32 multiplier, a two-bit-per-cycle divider and accumulators.
// ----------------------------------------------------------------------------
module bsce_dp import bsce_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int MAX_CTRL   = DEF_MAX_CTRL,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  st,
	input  logic [INDEX_W-1:0]    in_index,
	input  logic [KNOT_W-1:0]     in_param,
	input  logic [COORD_W-1:0]    in_x,
	input  logic [COORD_W-1:0]    in_y,
	input  logic [COORD_W-1:0]    in_z,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_W-1:0]    point_x,
	output logic [COORD_W-1:0]    point_y,
	output logic [COORD_W-1:0]    point_z,
	output logic [SPAN_W-1:0]     span_found,
	output logic [STATUS_W-1:0]   status
);

	localparam int KNOT_DEPTH = MAX_CTRL + MAX_DEGREE + 1;
	localparam int IW      = $clog2(KNOT_DEPTH);
	localparam int CW      = $clog2(MAX_CTRL);
	localparam int JW      = $clog2(MAX_DEGREE + 1);
	localparam int LW      = KNOT_W + 1;
	localparam int DENW    = KNOT_W + 1;
	localparam int DIVN    = BASIS_W + KNOT_W;
	localparam int DIV_CYC = (DIVN + 1) / 2;
	localparam int DIV_W   = 2 * DIV_CYC;
	localparam int DCW     = $clog2(DIV_CYC);
	localparam int AW      = 64 - FRAC_BITS + 4;
	localparam int PTW     = 3 * COORD_W;

	logic [KNOT_W-1:0] knot_mem [KNOT_DEPTH];
	logic [PTW-1:0]    ctrl_mem [MAX_CTRL];
	logic [KNOT_W-1:0] kdata_q;
	logic [PTW-1:0]    cdata_q;

	logic [DEG_W-1:0]  deg_q;
	logic [LAST_W-1:0] last_q;

	logic [KNOT_W-1:0] u_q;
	logic [JW-1:0]     p_q;
	logic [CW-1:0]     n_q;
	logic [IW-1:0]     low_q, high_q, mid, kraddr;
	logic [IW:0]       msum;
	logic              krd, kwr, cwr;

	logic signed [LW-1:0]      left_q  [MAX_DEGREE+1];
	logic signed [LW-1:0]      right_q [MAX_DEGREE+1];
	logic signed [BASIS_W-1:0] basis_q [MAX_DEGREE+1];
	logic signed [BASIS_W-1:0] saved_q;
	logic signed [DENW:0]      den_c, den_q;
	logic signed [DIV_W:0]     a_q, quot_s;

	logic [JW-1:0] rix, r1ix, jrix, jix, tix;

	logic signed [BASIS_W-1:0] mul_a;
	logic signed [COORD_W-1:0] mul_b;
	logic signed [63:0]        prod_c, prod_q, pmag, term;

	logic [DENW-1:0]  dmag_q, rem_q, rem_n;
	logic [DIV_W-1:0] dvd_q, dvd_n;
	logic [DENW:0]    remx;
	logic             div_neg_q, div_busy_q;
	logic [DCW-1:0]   div_cnt_q;

	logic signed [AW-1:0]      acc_q [3];
	logic signed [COORD_W-1:0] coord_sel;
	logic zero_q, sat_q, ov_q;
	sat_t sat_new, sat_old, sx, sy, sz;

	logic [JW-1:0]  p_cl;
	logic [CW-1:0]  n_cl;

	logic [COORD_W-1:0]  px_q, py_q, pz_q;
	logic [SPAN_W-1:0]   span_q;
	logic [STATUS_W-1:0] stat_q;

	assign rix  = JW'(cmd.r);
	assign r1ix = JW'(cmd.r) + JW'(1);
	assign jrix = JW'(cmd.j) - JW'(cmd.r);
	assign jix  = JW'(cmd.j);
	assign tix  = JW'(cmd.t);

	assign p_cl = (deg_q == '0) ? JW'(1) :
		(32'(deg_q) > MAX_DEGREE) ? JW'(MAX_DEGREE) : JW'(deg_q);
	assign n_cl = (last_q == '0) ? CW'(1) :
		(32'(last_q) > MAX_CTRL - 1) ? CW'(MAX_CTRL - 1) : CW'(last_q);

	// Span search and knot memory access
	assign msum = {1'b0, low_q} + {1'b0, high_q};
	assign mid  = msum[IW:1];

	always_comb begin
		krd = 1'b1;
		case (cmd.op)
			OP_RD_END:   kraddr = IW'(n_q) + IW'(1);
			OP_RD_MID:   kraddr = mid;
			OP_RD_LEFT:  kraddr = low_q + IW'(1) - IW'(cmd.j);
			OP_RD_RIGHT: kraddr = low_q + IW'(cmd.j);
			default: begin
				kraddr = mid;
				krd = 1'b0;
			end
		endcase
	end

	assign kwr = (cmd.op == OP_WR_KNOT) && (32'(in_index) < KNOT_DEPTH);
	assign cwr = (cmd.op == OP_WR_CTRL) && (32'(in_index) < MAX_CTRL);

	always_ff @(posedge clk) begin
		if (kwr) knot_mem[IW'(in_index)] <= in_param;
		if (krd) kdata_q <= knot_mem[kraddr];
	end

	always_ff @(posedge clk) begin
		if (cwr) ctrl_mem[CW'(in_index)] <= {in_z, in_y, in_x};
		if (cmd.op == OP_RD_CTRL)
			cdata_q <= ctrl_mem[CW'(low_q - IW'(p_q) + IW'(cmd.t))];
	end

	// Shared multiplier
	always_comb begin
		case (cmd.c)
			2'd0:    coord_sel = signed'(cdata_q[COORD_W-1:0]);
			2'd1:    coord_sel = signed'(cdata_q[2*COORD_W-1:COORD_W]);
			default: coord_sel = signed'(cdata_q[3*COORD_W-1:2*COORD_W]);
		endcase
		case (cmd.op)
			OP_MUL_A: begin
				mul_a = basis_q[rix];
				mul_b = COORD_W'(right_q[r1ix]);
			end
			OP_MUL_B: begin
				mul_a = basis_q[rix];
				mul_b = COORD_W'(left_q[jrix]);
			end
			default: begin
				mul_a = basis_q[tix];
				mul_b = coord_sel;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;
	assign den_c  = (DENW+1)'(right_q[r1ix]) + (DENW+1)'(left_q[jrix]);
	assign pmag   = prod_q[63] ? -prod_q : prod_q;
	assign term   = (prod_q + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

	// Divider, two quotient bits per cycle, on magnitudes
	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		remx  = '0;
		for (int i = 0; i < 2; i++) begin
			remx  = {rem_n, dvd_n[DIV_W-1]};
			dvd_n = {dvd_n[DIV_W-2:0], 1'b0};
			if (remx >= {1'b0, dmag_q}) begin
				remx = remx - {1'b0, dmag_q};
				dvd_n[0] = 1'b1;
			end
			rem_n = remx[DENW-1:0];
		end
	end

	assign quot_s = div_neg_q ? -signed'({1'b0, dvd_q}) : signed'({1'b0, dvd_q});

	assign sat_new = sat32(64'(saved_q) + 64'(a_q));
	assign sat_old = sat32(64'(quot_s));
	assign sx = sat32(64'(acc_q[0]));
	assign sy = sat32(64'(acc_q[1]));
	assign sz = sat32(64'(acc_q[2]));

	// Registers with reset: configuration, basis scratch, flags, handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= RST_DEGREE;
			last_q <= RST_LAST;
			for (int i = 0; i <= MAX_DEGREE; i++) basis_q[i] <= '0;
			zero_q <= 1'b0;
			sat_q <= 1'b0;
			ov_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DEGREE: deg_q <= cfg_wdata[DEG_W-1:0];
					REG_LAST:   last_q <= cfg_wdata[LAST_W-1:0];
					default:    deg_q <= deg_q;
				endcase
			end
			if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + DCW'(1);
				if (div_cnt_q == DCW'(DIV_CYC - 1)) div_busy_q <= 1'b0;
			end
			// A new result fills the output register; a taken one empties it.
			if (cmd.op == OP_FIN) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					basis_q[0] <= BASIS_W'(1) << FRAC_BITS;
					zero_q <= 1'b0;
					sat_q <= 1'b0;
				end
				OP_DEN: begin
					if (den_c == '0) begin
						basis_q[rix] <= saved_q;
						zero_q <= 1'b1;
					end
				end
				OP_DIV_START: begin
					div_busy_q <= 1'b1;
					div_cnt_q <= '0;
				end
				OP_UPD: begin
					basis_q[rix] <= sat_new.val;
					sat_q <= sat_q | sat_new.hit | sat_old.hit;
				end
				OP_ENDJ: basis_q[jix] <= saved_q;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (div_busy_q) begin
			rem_q <= rem_n;
			dvd_q <= dvd_n;
		end
		case (cmd.op)
			OP_LOAD: begin
				u_q <= in_param;
				p_q <= p_cl;
				n_q <= n_cl;
				low_q <= IW'(p_cl);
				high_q <= IW'(n_cl) + IW'(1);
				saved_q <= '0;
				for (int c = 0; c < 3; c++) acc_q[c] <= '0;
			end
			OP_CK_END: if (u_q >= kdata_q) low_q <= IW'(n_q);
			OP_CK_MID: begin
				if (u_q < kdata_q) high_q <= mid;
				else low_q <= mid;
			end
			OP_SET_LEFT:  left_q[jix] <= signed'({1'b0, u_q}) - signed'({1'b0, kdata_q});
			OP_SET_RIGHT: right_q[jix] <= signed'({1'b0, kdata_q}) - signed'({1'b0, u_q});
			OP_DEN: begin
				den_q <= den_c;
				if (den_c == '0) saved_q <= '0;
			end
			OP_MUL_A, OP_MUL_B, OP_MUL_P: prod_q <= prod_c;
			OP_DIV_START: begin
				dvd_q <= DIV_W'(pmag);
				rem_q <= '0;
				dmag_q <= den_q[DENW] ? DENW'(-den_q) : DENW'(den_q);
				div_neg_q <= prod_q[63] ^ den_q[DENW];
			end
			OP_SAVE_A: a_q <= quot_s;
			OP_UPD: saved_q <= sat_old.val;
			OP_ENDJ: saved_q <= '0;
			OP_ACC: acc_q[cmd.c] <= acc_q[cmd.c] + AW'(term);
			OP_FIN: begin
				px_q <= sx.val;
				py_q <= sy.val;
				pz_q <= sz.val;
				span_q <= SPAN_W'(low_q);
				stat_q <= zero_q ? ST_ZERO :
					(sat_q | sx.hit | sy.hit | sz.hit) ? ST_SAT : ST_OK;
			end
			default: u_q <= u_q;
		endcase
	end

	assign st.p         = CNT_W'(p_q);
	assign st.end_hit   = (u_q >= kdata_q);
	assign st.srch_done = ((high_q - low_q) <= IW'(1));
	assign st.den_zero  = (den_c == '0);
	assign st.div_done  = ~div_busy_q;
	assign st.out_free  = ~ov_q | out_ready;

	assign out_valid  = ov_q;
	assign point_x    = px_q;
	assign point_y    = py_q;
	assign point_z    = pz_q;
	assign span_found = span_q;
	assign status     = stat_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIV_START) |-> !div_busy_q)
		else $error("divider restarted while busy");

	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIN) |-> (!ov_q || out_ready))
		else $error("result written over one not yet taken");

	a_end_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CK_END) |-> ($past(cmd.op) == OP_RD_END))
		else $error("end knot compared without a fresh read");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for bspline_curve_point_eval
// Drives knot writes, control point writes and curve evaluations under a
// range of degree and control point count settings, predicts every curve
// point in the bench and compares each returned point field by field.
// ----------------------------------------------------------------------------

typedef struct {
	logic [31:0] px;
	logic [31:0] py;
	logic [31:0] pz;
	logic [5:0]  span;
	logic [1:0]  status;
} curve_point_t;

// Keeps its own copy of the knot and control point stores and the two
// registers, and works out the point that each evaluation request must give.
class curve_point_tracker;

	bit [16:0]    knots[36];
	int           cx[32];
	int           cy[32];
	int           cz[32];
	int unsigned  degree_reg = 3;
	int unsigned  last_reg   = 3;
	curve_point_t pending_points[$];
	int           errors;
	bit           sat_seen;

	function void set_reg(logic [bsce_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		if (idx == bsce_pkg::REG_DEGREE)
			degree_reg = val & 3;
		else
			last_reg = val & 31;
	endfunction

	function longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			sat_seen = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat_seen = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Nearest Q16.16 value, ties going upward.
	function longint round_q16(longint v);
		longint y;
		y = v + 32768;
		if (y >= 0)
			return y >>> 16;
		return -((-y + 65535) >>> 16);
	endfunction

	function void note_request(logic [1:0] mode, logic [5:0] idx, logic [16:0] u,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int unsigned  p, n, s, lo, hi, mid;
		longint       nb[4], lft[4], rgt[4], saved, den, a, b, acc, uu;
		bit           zero_seen;
		curve_point_t pt;
		if (mode == bsce_pkg::MODE_KNOT) begin
			if (idx < 36)
				knots[idx] = u;
			return;
		end
		if (mode == bsce_pkg::MODE_CTRL) begin
			if (idx < 32) begin
				cx[idx] = x;
				cy[idx] = y;
				cz[idx] = z;
			end
			return;
		end
		if (mode != bsce_pkg::MODE_EVAL)
			return;
		p = (degree_reg < 1) ? 1 : degree_reg;
		n = (last_reg < 1) ? 1 : last_reg;
		uu = u;
		sat_seen = 0;
		zero_seen = 0;
		// span search; past the last interior knot the span is n itself
		if (uu >= knots[n+1]) begin
			s = n;
		end else begin
			lo = p;
			hi = n + 1;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (uu < knots[mid])
					hi = mid;
				else
					lo = mid;
			end
			s = lo;
		end
		// triangular recurrence, a zero knot interval gives a zero term
		nb[0] = 64'sd65536;
		for (int j = 1; j <= p; j++) begin
			saved = 0;
			lft[j] = uu - longint'(knots[s+1-j]);
			rgt[j] = longint'(knots[s+j]) - uu;
			for (int r = 0; r < j; r++) begin
				den = rgt[r+1] + lft[j-r];
				if (den == 0) begin
					zero_seen = 1;
					nb[r] = saved;
					saved = 0;
				end else begin
					a = (nb[r] * rgt[r+1]) / den;
					b = (nb[r] * lft[j-r]) / den;
					nb[r] = clip32(saved + a);
					saved = clip32(b);
				end
			end
			nb[j] = saved;
		end
		acc = 0;
		for (int r = 0; r <= p; r++)
			acc += round_q16(longint'(cx[s-p+r]) * nb[r]);
		pt.px = 32'(clip32(acc));
		acc = 0;
		for (int r = 0; r <= p; r++)
			acc += round_q16(longint'(cy[s-p+r]) * nb[r]);
		pt.py = 32'(clip32(acc));
		acc = 0;
		for (int r = 0; r <= p; r++)
			acc += round_q16(longint'(cz[s-p+r]) * nb[r]);
		pt.pz = 32'(clip32(acc));
		pt.span = 6'(s);
		pt.status = zero_seen ? bsce_pkg::ST_ZERO :
			(sat_seen ? bsce_pkg::ST_SAT : bsce_pkg::ST_OK);
		pending_points.insert(pending_points.size(), pt);
	endfunction

	function void check_point(logic [bsce_pkg::M_TDATA_W-1:0] data, logic [1:0] status,
			longint unsigned now);
		curve_point_t e;
		if (pending_points.size() == 0) begin
			$display("%0t: point %h status %0d returned with none expected",
				now, data, status);
			errors++;
			return;
		end
		e = pending_points.pop_front();
		if (data[31:0] !== e.px) begin
			$display("%0t: point_x expected %h actual %h", now, e.px, data[31:0]);
			errors++;
		end
		if (data[63:32] !== e.py) begin
			$display("%0t: point_y expected %h actual %h", now, e.py, data[63:32]);
			errors++;
		end
		if (data[95:64] !== e.pz) begin
			$display("%0t: point_z expected %h actual %h", now, e.pz, data[95:64]);
			errors++;
		end
		if (data[101:96] !== e.span) begin
			$display("%0t: span_found expected %0d actual %0d", now, e.span,
				data[101:96]);
			errors++;
		end
		if (status !== e.status) begin
			$display("%0t: status expected %0d actual %0d", now, e.status, status);
			errors++;
		end
	endfunction
endclass

module testbench import bsce_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 450;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	curve_point_tracker tracker = new();
	// when set, neither side inserts idle cycles
	bit                 calm;
	int                 quiet_cycles;
	int                 sent;

	bspline_curve_point_eval dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: checks every accepted result and stalls now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				tracker.check_point(m_tdata, m_tuser, $time);
			m_tready <= calm || ($urandom_range(99) >= 10);
		end
	end

	// Watchdog: the count restarts whenever either stream or the register
	// port moves something.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("bspline_curve_point_eval: mismatch");
			$finish;
		end
	end

	// One request on the slave stream, with the odd idle cycle in front.
	task automatic send_request(logic [1:0] mode, logic [5:0] idx, logic [16:0] u,
			logic [31:0] x = 0, logic [31:0] y = 0, logic [31:0] z = 0);
		while (!calm && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {1'b0, z, y, x, u, idx};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_request(mode, idx, u, x, y, z);
		sent++;
	endtask

	// Holds the sender back until every expected point is home and the
	// block has had time to finish anything that gives no result.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_reg(idx, val);
	endtask

	function automatic logic [16:0] any_param();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	function automatic logic [31:0] any_coord();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($urandom_range(131072)) - 32'd65536;
			default: return $urandom();
		endcase
	endfunction

	// Writes knots 0 to n+p+1 for the current setting. Most vectors are
	// clamped and sorted; coarse steps give repeated knots and so zero
	// intervals, and now and then the vector is left unsorted.
	task automatic load_knots();
		int unsigned p, n, top, kind;
		logic [16:0] vals[$];
		p = (tracker.degree_reg < 1) ? 1 : tracker.degree_reg;
		n = (tracker.last_reg < 1) ? 1 : tracker.last_reg;
		top = n + p + 1;
		kind = $urandom_range(9);
		vals.delete();
		for (int i = 0; i <= top; i++) begin
			if (kind < 4)
				vals.insert(vals.size(), 17'($urandom_range(65536)));
			else if (kind < 8)
				vals.insert(vals.size(), 17'($urandom_range(8) * 8192));
			else
				vals.insert(vals.size(), any_param());
		end
		if (kind < 8) begin
			vals.sort();
			if (kind < 6) begin
				for (int i = 0; i <= p; i++) begin
					vals[i] = 17'd0;
					vals[top-i] = 17'd65536;
				end
			end
		end
		for (int i = 0; i <= top; i++)
			send_request(MODE_KNOT, 6'(i), vals[i]);
	endtask

	task automatic evaluate_somewhere();
		int unsigned k;
		if ($urandom_range(3) == 0) begin
			k = $urandom_range(35);
			send_request(MODE_EVAL, 6'($urandom()), tracker.knots[k], $urandom(),
				$urandom(), $urandom());
		end else begin
			send_request(MODE_EVAL, 6'($urandom()), any_param(), $urandom(),
				$urandom(), $urandom());
		end
	endtask

	initial begin
		int unsigned degrees[8] = '{3, 1, 3, 2, 0, 1, 2, 3};
		int unsigned lasts[8]   = '{3, 1, 31, 10, 0, 31, 5, 17};
		int unsigned pick, quota;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_KNOT;
		cfg_wr_en = 1'b0;
		cfg_index = REG_DEGREE;
		cfg_wdata = '0;
		calm      = 1'b0;
		sent      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every store entry is filled first so that no evaluation reads an
		// entry the block never saw. Corners hold the coordinate extremes.
		for (int i = 0; i < 36; i++)
			send_request(MODE_KNOT, 6'(i), (i < 4) ? 17'd0 :
				((i > 31) ? 17'd65536 : 17'((i - 3) * 2340)));
		for (int i = 0; i < 32; i++)
			send_request(MODE_CTRL, 6'(i), 17'd0,
				(i % 2) ? 32'h7fffffff : 32'h80000000,
				(i % 3) ? 32'h00010000 : 32'hffff0000, $urandom());

		// Directed part at the reset setting: both ends of u, u at and
		// before the first interior knot, knot writes and control writes
		// past their stores, and the unused mode.
		send_request(MODE_EVAL, 6'd0, 17'd0);
		send_request(MODE_EVAL, 6'd63, 17'd65536);
		send_request(MODE_EVAL, 6'd0, 17'd32768);
		send_request(MODE_EVAL, 6'd0, 17'd2340);
		send_request(MODE_EVAL, 6'd0, 17'd1);
		send_request(MODE_KNOT, 6'd36, 17'd12345);
		send_request(MODE_KNOT, 6'd63, 17'h1ffff);
		send_request(MODE_CTRL, 6'd32, 17'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_request(MODE_CTRL, 6'd63, 17'h1ffff, 32'h0, 32'h0, 32'h0);
		send_request(2'd3, 6'd5, 17'd100, $urandom(), $urandom(), $urandom());
		// a repeated knot in the middle of the span gives a zero interval
		send_request(MODE_KNOT, 6'd4, 17'd0);
		send_request(MODE_EVAL, 6'd0, 17'd10);
		send_request(MODE_EVAL, 6'd0, 17'd65535);

		// Random part, one phase per register setting. The sender always
		// waits for the block to empty before a register changes.
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(REG_DEGREE, 5'(degrees[ph]));
			write_reg(REG_LAST, 5'(lasts[ph]));
			calm = (ph == 2);
			load_knots();
			quota = sent + 212;
			while (sent < quota) begin
				pick = $urandom_range(99);
				if (pick < 45)
					evaluate_somewhere();
				else if (pick < 70)
					send_request(MODE_CTRL, 6'($urandom_range(31)), 17'($urandom()),
						any_coord(), any_coord(), any_coord());
				else if (pick < 74)
					load_knots();
				else if (pick < 80)
					send_request(MODE_KNOT, 6'($urandom_range(35)), any_param());
				else if (pick < 85)
					send_request(2'd3, 6'($urandom()), 17'($urandom()), $urandom(),
						$urandom(), $urandom());
				else if (pick < 90)
					send_request(MODE_KNOT, 6'($urandom_range(63, 36)), 17'($urandom()));
				else if (pick < 95)
					send_request(MODE_CTRL, 6'($urandom_range(63, 32)), 17'($urandom()),
						$urandom(), $urandom(), $urandom());
				else
					drain();
			end
		end

		drain();
		if (tracker.errors == 0)
			$display("bspline_curve_point_eval: match");
		else
			$display("bspline_curve_point_eval: mismatch");
		$finish;
	end
endmodule

### files.f
hdl/bsce_pkg.sv
hdl/bsce_ctrl.sv
hdl/bsce_dp.sv
hdl/bspline_curve_point_eval.sv
verif/testbench.sv
